// File: rtl/core/erx_pkg.sv
package erx_pkg;

   localparam int INSTR_W   = 16;
   localparam int OPCODE_W  = 4;
   localparam int REG_IDX_W = 6;
   localparam int REG_COUNT = 2 ** REG_IDX_W;
   localparam int IMM_W     = 6;
   localparam int IMM_RANGE = 2 ** IMM_W;
   localparam int DATA_W    = 8;
   localparam int PC_W      = 16;
   localparam int FLAGS_W   = 5;

   localparam logic [FLAGS_W-1:0] FLAGS_RESET = 5'b11111;

   // Bit positions inside the status flags.
   localparam int FLAG_C = 4;
   localparam int FLAG_V = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_S = 1;
   localparam int FLAG_Z = 0;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_LDI  = 4'd3,
      OP_BEQZ = 4'd4,
      OP_AND  = 4'd5,
      OP_OR   = 4'd6,
      OP_JR   = 4'd7,
      OP_SLC  = 4'd8,
      OP_SRC  = 4'd9,
      OP_LB   = 4'd10,
      OP_SB   = 4'd11
   } op_type;

   // Decoded instruction as it travels from the front end to the execute side.
   typedef struct packed {
      op_type                 op_code;
      logic                   bad_op;
      logic [REG_IDX_W-1:0]   r1_idx;
      logic [IMM_W-1:0]       low_field;
   } instr_type;

   typedef struct packed {
      logic [PC_W-1:0]        next_pc;
      logic                   branch_taken;
      logic                   write_enable;
      logic [REG_IDX_W-1:0]   write_index;
      logic [DATA_W-1:0]      write_value;
      logic [FLAGS_W-1:0]     flags_out;
      logic                   bad_opcode;
   } result_type;

endpackage

// File: rtl/core/erx_front.sv
module erx_front
   import erx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [INSTR_W-1:0]    req_instr_word,
   output logic                  q_valid,
   output instr_type             q_item,
   input  logic                  q_pop
);

   instr_type                 dec_item;
   instr_type                 slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]         wr_ptr_ff;
   logic [QPTR_W-1:0]         rd_ptr_ff;
   logic [QCNT_W-1:0]         count_ff;
   logic                      push;

   // Split the word into its fields and flag the unused opcodes.
   always_comb begin
      dec_item.op_code   = op_type'(req_instr_word[INSTR_W-1 -: OPCODE_W]);
      dec_item.r1_idx    = req_instr_word[IMM_W +: REG_IDX_W];
      dec_item.low_field = req_instr_word[IMM_W-1:0];
      case (req_instr_word[INSTR_W-1 -: OPCODE_W]) inside
         [OP_ADD:OP_SB]: begin
            dec_item.bad_op = 1'b0;
         end
         default: begin
            dec_item.bad_op = 1'b1;
         end
      endcase
   end

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= dec_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !q_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push && q_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: rtl/core/erx_back.sv
module erx_back
   import erx_pkg::*;
#(
   parameter int DATA_BYTES = 2048
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   input  instr_type             q_item,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output result_type            rsp_result
);

   // The data store is cut down to the bytes that the immediate can reach.
   localparam int STORE_DEPTH = (DATA_BYTES < IMM_RANGE) ? DATA_BYTES : IMM_RANGE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   typedef enum logic [1:0] {
      SRC_MEM,
      SRC_ZERO,
      SRC_FWD
   } src_type;

   logic [DATA_W-1:0]         reg_mem   [REG_COUNT];
   logic [DATA_W-1:0]         store_mem [STORE_DEPTH];
   logic [REG_COUNT-1:0]      reg_written_ff;
   logic [STORE_DEPTH-1:0]    store_written_ff;

   instr_type                 ex_item_ff;
   logic                      ex_valid_ff;
   logic [DATA_W-1:0]         rd_a_ff;
   logic [DATA_W-1:0]         rd_b_ff;
   logic [DATA_W-1:0]         rd_m_ff;
   src_type                   src_a_ff;
   src_type                   src_b_ff;
   src_type                   src_m_ff;
   logic [DATA_W-1:0]         fwd_reg_ff;
   logic [DATA_W-1:0]         fwd_store_ff;

   logic [PC_W-1:0]           pc_ff;
   logic [FLAGS_W-1:0]        flags_ff;
   logic                      rsp_valid_ff;
   result_type                rsp_ff;

   logic                      fire;
   logic [ADDR_W-1:0]         pop_addr;
   logic [ADDR_W-1:0]         ex_addr;
   logic [DATA_W-1:0]         op_a;
   logic [DATA_W-1:0]         op_b;
   logic [DATA_W-1:0]         op_m;
   logic [DATA_W:0]           sum;
   logic [2*DATA_W-1:0]       product;
   logic [2*DATA_W-1:0]       rot_left;
   logic [2*DATA_W-1:0]       rot_right;
   logic [PC_W-1:0]           pc_plus1;
   logic [DATA_W-1:0]         res;
   logic                      reg_we;
   logic                      store_we;
   logic                      taken;
   logic                      set_nz;
   logic [PC_W-1:0]           pc_in;
   logic [FLAGS_W-1:0]        flags_in;
   src_type                   src_a_in;
   src_type                   src_b_in;
   src_type                   src_m_in;

   assign fire      = ex_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign q_pop     = q_valid && (!ex_valid_ff || fire);
   assign pop_addr  = q_item.low_field[ADDR_W-1:0];
   assign ex_addr   = ex_item_ff.low_field[ADDR_W-1:0];

   // A write that retires at the same edge as the read is taken from the
   // forward register; an entry never written reads as zero.
   always_comb begin
      if (fire && reg_we && ex_item_ff.r1_idx == q_item.r1_idx) begin
         src_a_in = SRC_FWD;
      end else if (!reg_written_ff[q_item.r1_idx]) begin
         src_a_in = SRC_ZERO;
      end else begin
         src_a_in = SRC_MEM;
      end
      if (fire && reg_we && ex_item_ff.r1_idx == q_item.low_field) begin
         src_b_in = SRC_FWD;
      end else if (!reg_written_ff[q_item.low_field]) begin
         src_b_in = SRC_ZERO;
      end else begin
         src_b_in = SRC_MEM;
      end
      if (fire && store_we && ex_addr == pop_addr) begin
         src_m_in = SRC_FWD;
      end else if (!store_written_ff[pop_addr]) begin
         src_m_in = SRC_ZERO;
      end else begin
         src_m_in = SRC_MEM;
      end
   end

   always_comb begin
      case (src_a_ff)
         SRC_FWD:  op_a = fwd_reg_ff;
         SRC_ZERO: op_a = '0;
         default:  op_a = rd_a_ff;
      endcase
      case (src_b_ff)
         SRC_FWD:  op_b = fwd_reg_ff;
         SRC_ZERO: op_b = '0;
         default:  op_b = rd_b_ff;
      endcase
      case (src_m_ff)
         SRC_FWD:  op_m = fwd_store_ff;
         SRC_ZERO: op_m = '0;
         default:  op_m = rd_m_ff;
      endcase
   end

   assign sum       = {1'b0, op_a} + {1'b0, op_b};
   assign product   = op_a * op_b;
   assign rot_left  = {op_a, op_a} << ex_item_ff.low_field[2:0];
   assign rot_right = {op_a, op_a} >> ex_item_ff.low_field[2:0];
   assign pc_plus1  = pc_ff + 1'b1;

   always_comb begin
      res      = '0;
      reg_we   = 1'b0;
      store_we = 1'b0;
      taken    = 1'b0;
      set_nz   = 1'b0;
      pc_in    = pc_plus1;
      flags_in = flags_ff;
      case (ex_item_ff.op_code)
         OP_ADD: begin
            res              = sum[DATA_W-1:0];
            reg_we           = 1'b1;
            set_nz           = 1'b1;
            flags_in[FLAG_C] = sum[DATA_W];
            flags_in[FLAG_V] = ~(op_a[DATA_W-1] ^ op_b[DATA_W-1])
                             & (op_a[DATA_W-1] ^ res[DATA_W-1]);
         end
         OP_SUB: begin
            res              = op_a - op_b;
            reg_we           = 1'b1;
            set_nz           = 1'b1;
            flags_in[FLAG_V] = (op_a[DATA_W-1] ^ op_b[DATA_W-1])
                             & (op_a[DATA_W-1] ^ res[DATA_W-1]);
         end
         OP_MUL: begin
            res    = product[DATA_W-1:0];
            reg_we = 1'b1;
            set_nz = 1'b1;
         end
         OP_LDI: begin
            res    = DATA_W'(ex_item_ff.low_field);
            reg_we = 1'b1;
         end
         OP_BEQZ: begin
            if (op_a == '0) begin
               taken = 1'b1;
               pc_in = pc_plus1 + PC_W'(ex_item_ff.low_field);
            end
         end
         OP_AND: begin
            res    = op_a & op_b;
            reg_we = 1'b1;
            set_nz = 1'b1;
         end
         OP_OR: begin
            res    = op_a | op_b;
            reg_we = 1'b1;
            set_nz = 1'b1;
         end
         OP_JR: begin
            taken = 1'b1;
            pc_in = {op_a, op_b};
         end
         OP_SLC: begin
            res    = rot_left[2*DATA_W-1:DATA_W];
            reg_we = 1'b1;
            set_nz = 1'b1;
         end
         OP_SRC: begin
            res    = rot_right[DATA_W-1:0];
            reg_we = 1'b1;
            set_nz = 1'b1;
         end
         OP_LB: begin
            res    = op_m;
            reg_we = 1'b1;
         end
         OP_SB: begin
            store_we = 1'b1;
         end
         default: begin
         end
      endcase
      if (set_nz) begin
         flags_in[FLAG_N] = res[DATA_W-1];
         flags_in[FLAG_Z] = (res == '0);
      end
      // Only ADD and SUB move V, so S follows N xor V whenever they run.
      if (ex_item_ff.op_code == OP_ADD || ex_item_ff.op_code == OP_SUB) begin
         flags_in[FLAG_S] = flags_in[FLAG_N] ^ flags_in[FLAG_V];
      end
   end

   // Register file: two reads at issue, one write at retirement.
   always_ff @(posedge clock) begin
      if (fire && reg_we) begin
         reg_mem[ex_item_ff.r1_idx] <= res;
      end
      if (q_pop) begin
         rd_a_ff <= reg_mem[q_item.r1_idx];
         rd_b_ff <= reg_mem[q_item.low_field];
      end
   end

   always_ff @(posedge clock) begin
      if (fire && store_we) begin
         store_mem[ex_addr] <= op_a;
      end
      if (q_pop) begin
         rd_m_ff <= store_mem[pop_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         ex_item_ff <= q_item;
         src_a_ff   <= src_a_in;
         src_b_ff   <= src_b_in;
         src_m_ff   <= src_m_in;
      end
      if (fire) begin
         fwd_reg_ff   <= res;
         fwd_store_ff <= op_a;
         rsp_ff.next_pc      <= pc_in;
         rsp_ff.branch_taken <= taken;
         rsp_ff.write_enable <= reg_we;
         rsp_ff.write_index  <= reg_we ? ex_item_ff.r1_idx : '0;
         rsp_ff.write_value  <= reg_we ? res : '0;
         rsp_ff.flags_out    <= flags_in;
         rsp_ff.bad_opcode   <= ex_item_ff.bad_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         pc_ff            <= '0;
         flags_ff         <= FLAGS_RESET;
         reg_written_ff   <= '0;
         store_written_ff <= '0;
      end else begin
         if (q_pop) begin
            ex_valid_ff <= 1'b1;
         end else if (fire) begin
            ex_valid_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fire) begin
            pc_ff    <= pc_in;
            flags_ff <= flags_in;
            if (reg_we) begin
               reg_written_ff[ex_item_ff.r1_idx] <= 1'b1;
            end
            if (store_we) begin
               store_written_ff[ex_addr] <= 1'b1;
            end
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

endmodule

// File: rtl/core/eight_bit_risc_execute_unit.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_instr_word
// rsp       out        rsp_valid / rsp_stall  rsp_next_pc, rsp_branch_taken, rsp_write_enable,
//                                             rsp_write_index, rsp_write_value,
//                                             rsp_flags_out, rsp_bad_opcode
//
// One item is taken and one result is delivered per clock when neither side stalls.
// An item is written into the queue at the edge that accepts it; its operands are read into the
// operand registers as it leaves the queue, and it is then executed into the output register,
// from which its result can be taken.
// The rate is set by the single execute stage, whose register file and data store
// writes are bypassed to the next item's operand reads.
// Reset (synchronous, active high) zeroes the program counter, sets all five flags and
// marks every register and data byte as unwritten, so they read as zero.
// A stall on rsp holds the execute stage; the two-entry queue then fills and raises req_stall.
module eight_bit_risc_execute_unit
   import erx_pkg::*;
#(
   parameter int DATA_BYTES = 2048
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [INSTR_W-1:0]    req_instr_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PC_W-1:0]       rsp_next_pc,
   output logic                  rsp_branch_taken,
   output logic                  rsp_write_enable,
   output logic [REG_IDX_W-1:0]  rsp_write_index,
   output logic [DATA_W-1:0]     rsp_write_value,
   output logic [FLAGS_W-1:0]    rsp_flags_out,
   output logic                  rsp_bad_opcode
);

   // Decoded items waiting between the front end and the execute side.
   logic        q_valid;
   logic        q_pop;
   instr_type   q_item;
   result_type  rsp_result;

   // The front end decodes each item and parks it in a short queue, so input
   // acceptance does not wait on the execute side directly.
   erx_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_instr_word (req_instr_word),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   // The back end reads operands, executes, updates the architectural state
   // and holds the result in an output register until it is taken.
   erx_back #(
      .DATA_BYTES (DATA_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   assign rsp_next_pc      = rsp_result.next_pc;
   assign rsp_branch_taken = rsp_result.branch_taken;
   assign rsp_write_enable = rsp_result.write_enable;
   assign rsp_write_index  = rsp_result.write_index;
   assign rsp_write_value  = rsp_result.write_value;
   assign rsp_flags_out    = rsp_result.flags_out;
   assign rsp_bad_opcode   = rsp_result.bad_opcode;

endmodule
